// File: src/rcm_pkg.sv
package rcm_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int CHAN_BITS     = 8;
    localparam int CHAN_COUNT    = 4;
    localparam int COLOR_BITS    = CHAN_BITS * CHAN_COUNT;
    localparam int TIME_BITS     = 64;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_RECT_LEFT    = 3'd0,
        REG_RECT_TOP     = 3'd1,
        REG_RECT_WIDTH   = 3'd2,
        REG_RECT_HEIGHT  = 3'd3,
        REG_TARGET_COLOR = 3'd4,
        REG_TOLERANCE    = 3'd5,
        REG_INVERT       = 3'd6
    } t_reg_index;

    typedef struct packed {
        logic [COLOR_BITS-1:0] target_color;
        logic [CHAN_BITS-1:0]  tolerance;
        logic                  invert;
    } t_color_cfg;

endpackage

// File: src/region_color_match_monitor.sv
// region_color_match_monitor
// Watches one rectangle of a BGRA pixel stream and reports when the region's
// match state changes.
// Pixel channel: i_pix_valid / o_pix_ready, one pixel per beat in raster order
// with its column, row, frame-end mark and frame timestamp.
// Event channel: o_evt_valid / i_evt_ready, at most one beat per frame, sent
// from the frame-end pixel when the frame result differs from the last state
// reported.
// Config port: i_cfg_we / i_cfg_addr / i_cfg_data, written while idle; any
// write to a known register clears the reported state.
// Throughput: one pixel per cycle while no event stalls. Path: a frame-end
// pixel is held in the input register, then its event in the event register.
// Stall: an event waiting in the output register holds the input register;
// pixel ready then drops once the input register is full.
// Reset: synchronous, active low; clears the control registers, frame result
// to pass, reported state to not matching, no event pending.
module region_color_match_monitor #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcm_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [rcm_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_pix_valid,
    output logic                              o_pix_ready,
    input  logic [rcm_pkg::COLOR_BITS-1:0]    i_pixel_color,
    input  logic [COORD_BITS-1:0]             i_pixel_x,
    input  logic [COORD_BITS-1:0]             i_pixel_y,
    input  logic                              i_frame_end,
    input  logic [rcm_pkg::TIME_BITS-1:0]     i_frame_time,
    output logic                              o_evt_valid,
    input  logic                              i_evt_ready,
    output logic                              o_match_state,
    output logic                              o_previous_state,
    output logic [rcm_pkg::TIME_BITS-1:0]     o_event_time
);

    logic [COORD_BITS-1:0] w_rect_left;
    logic [COORD_BITS-1:0] w_rect_top;
    logic [COORD_BITS-1:0] w_rect_width;
    logic [COORD_BITS-1:0] w_rect_height;
    rcm_pkg::t_color_cfg   w_color_cfg;
    logic                  w_cfg_hit;

    logic                              r_in_valid;
    logic [rcm_pkg::COLOR_BITS-1:0]    r_in_color;
    logic [COORD_BITS-1:0]             r_in_x;
    logic [COORD_BITS-1:0]             r_in_y;
    logic                              r_in_frame_end;
    logic [rcm_pkg::TIME_BITS-1:0]     r_in_time;

    logic                              r_frame_pass;
    logic                              r_reported;
    logic                              r_evt_valid;
    logic                              r_evt_match;
    logic                              r_evt_prev;
    logic [rcm_pkg::TIME_BITS-1:0]     r_evt_time;

    logic w_fail;
    logic w_advance;
    logic w_accept;
    logic w_step;
    logic w_now;
    logic w_evt_load;

    rcm_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_rect_left   (w_rect_left),
        .o_rect_top    (w_rect_top),
        .o_rect_width  (w_rect_width),
        .o_rect_height (w_rect_height),
        .o_color_cfg   (w_color_cfg),
        .o_cfg_hit     (w_cfg_hit)
    );

    rcm_pixel_judge #(
        .COORD_BITS (COORD_BITS)
    ) u_judge (
        .i_pixel_color (r_in_color),
        .i_pixel_x     (r_in_x),
        .i_pixel_y     (r_in_y),
        .i_rect_left   (w_rect_left),
        .i_rect_top    (w_rect_top),
        .i_rect_width  (w_rect_width),
        .i_rect_height (w_rect_height),
        .i_color_cfg   (w_color_cfg),
        .o_fail        (w_fail)
    );

    assign w_advance   = !r_evt_valid || i_evt_ready;
    assign o_pix_ready = !r_in_valid || w_advance;
    assign w_accept    = i_pix_valid && o_pix_ready;
    assign w_step      = r_in_valid && w_advance;
    assign w_now       = r_frame_pass && !w_fail;
    assign w_evt_load  = w_step && r_in_frame_end && (w_now != r_reported);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_color     <= i_pixel_color;
            r_in_x         <= i_pixel_x;
            r_in_y         <= i_pixel_y;
            r_in_frame_end <= i_frame_end;
            r_in_time      <= i_frame_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pass <= 1'b1;
        end else if (w_step) begin
            r_frame_pass <= r_in_frame_end ? 1'b1 : w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported <= 1'b0;
        end else if (w_cfg_hit) begin
            r_reported <= 1'b0;
        end else if (w_evt_load) begin
            r_reported <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_valid <= 1'b0;
        end else if (w_evt_load) begin
            r_evt_valid <= 1'b1;
        end else if (i_evt_ready) begin
            r_evt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt_load) begin
            r_evt_match <= w_now;
            r_evt_prev  <= r_reported;
            r_evt_time  <= r_in_time;
        end
    end

    assign o_evt_valid      = r_evt_valid;
    assign o_match_state    = r_evt_match;
    assign o_previous_state = r_evt_prev;
    assign o_event_time     = r_evt_time;

`ifndef SYNTH
    a_evt_is_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid |-> (o_match_state != o_previous_state))
        else $error("event without a state change");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_frame_end) |=> r_frame_pass)
        else $error("frame result not restarted after frame end");

    a_evt_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evt_load |-> (r_in_valid && r_in_frame_end && w_advance))
        else $error("event loaded outside a frame-end step");
`endif

endmodule

// File: src/rcm_cfg_regs.sv
module rcm_cfg_regs #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcm_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [rcm_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic [COORD_BITS-1:0]             o_rect_left,
    output logic [COORD_BITS-1:0]             o_rect_top,
    output logic [COORD_BITS-1:0]             o_rect_width,
    output logic [COORD_BITS-1:0]             o_rect_height,
    output rcm_pkg::t_color_cfg               o_color_cfg,
    output logic                              o_cfg_hit
);

    logic [COORD_BITS-1:0] r_rect_left;
    logic [COORD_BITS-1:0] r_rect_top;
    logic [COORD_BITS-1:0] r_rect_width;
    logic [COORD_BITS-1:0] r_rect_height;
    rcm_pkg::t_color_cfg   r_color_cfg;
    logic                  w_hit;

    always_comb begin
        case (i_cfg_addr)
            rcm_pkg::REG_RECT_LEFT,
            rcm_pkg::REG_RECT_TOP,
            rcm_pkg::REG_RECT_WIDTH,
            rcm_pkg::REG_RECT_HEIGHT,
            rcm_pkg::REG_TARGET_COLOR,
            rcm_pkg::REG_TOLERANCE,
            rcm_pkg::REG_INVERT: w_hit = i_cfg_we;
            default:             w_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left  <= '0;
            r_rect_top   <= '0;
            r_rect_width <= '0;
            r_rect_height <= '0;
            r_color_cfg  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rcm_pkg::REG_RECT_LEFT:    r_rect_left   <= i_cfg_data[COORD_BITS-1:0];
                rcm_pkg::REG_RECT_TOP:     r_rect_top    <= i_cfg_data[COORD_BITS-1:0];
                rcm_pkg::REG_RECT_WIDTH:   r_rect_width  <= i_cfg_data[COORD_BITS-1:0];
                rcm_pkg::REG_RECT_HEIGHT:  r_rect_height <= i_cfg_data[COORD_BITS-1:0];
                rcm_pkg::REG_TARGET_COLOR: r_color_cfg.target_color <=
                                               i_cfg_data[rcm_pkg::COLOR_BITS-1:0];
                rcm_pkg::REG_TOLERANCE:    r_color_cfg.tolerance <=
                                               i_cfg_data[rcm_pkg::CHAN_BITS-1:0];
                rcm_pkg::REG_INVERT:       r_color_cfg.invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_rect_left   = r_rect_left;
    assign o_rect_top    = r_rect_top;
    assign o_rect_width  = r_rect_width;
    assign o_rect_height = r_rect_height;
    assign o_color_cfg   = r_color_cfg;
    assign o_cfg_hit     = w_hit;

endmodule

// File: src/rcm_pixel_judge.sv
module rcm_pixel_judge #(
    parameter int COORD_BITS = 12
) (
    input  logic [rcm_pkg::COLOR_BITS-1:0] i_pixel_color,
    input  logic [COORD_BITS-1:0]          i_pixel_x,
    input  logic [COORD_BITS-1:0]          i_pixel_y,
    input  logic [COORD_BITS-1:0]          i_rect_left,
    input  logic [COORD_BITS-1:0]          i_rect_top,
    input  logic [COORD_BITS-1:0]          i_rect_width,
    input  logic [COORD_BITS-1:0]          i_rect_height,
    input  rcm_pkg::t_color_cfg            i_color_cfg,
    output logic                           o_fail
);

    localparam int CB = rcm_pkg::CHAN_BITS;

    logic [COORD_BITS:0]           w_right;
    logic [COORD_BITS:0]           w_bottom;
    logic                          w_inside;
    logic [rcm_pkg::CHAN_COUNT-1:0] w_chan_ok;
    logic                          w_pass;

    assign w_right  = {1'b0, i_rect_left} + {1'b0, i_rect_width};
    assign w_bottom = {1'b0, i_rect_top} + {1'b0, i_rect_height};
    assign w_inside = (i_pixel_x >= i_rect_left) && ({1'b0, i_pixel_x} < w_right)
                   && (i_pixel_y >= i_rect_top) && ({1'b0, i_pixel_y} < w_bottom);

    always_comb begin
        logic [CB-1:0] p;
        logic [CB-1:0] c;
        logic [CB:0]   hi_sum;
        logic [CB-1:0] hi;
        logic [CB-1:0] lo;
        for (int k = 0; k < rcm_pkg::CHAN_COUNT; k++) begin
            p      = i_pixel_color[k*CB +: CB];
            c      = i_color_cfg.target_color[k*CB +: CB];
            hi_sum = {1'b0, c} + {1'b0, i_color_cfg.tolerance};
            hi     = hi_sum[CB] ? rcm_pkg::CHAN_MAX : hi_sum[CB-1:0];
            lo     = (c >= i_color_cfg.tolerance) ? c - i_color_cfg.tolerance : '0;
            w_chan_ok[k] = (p >= lo) && (p <= hi);
        end
    end

    assign w_pass = (&w_chan_ok) ^ i_color_cfg.invert;
    assign o_fail = w_inside && !w_pass;

endmodule
